// ===== sv/rgbmix_pkg.sv =====
`timescale 1ns / 1ps

package rgbmix_pkg;

    // Mode codes
    localparam logic [1:0] MODE_MIX   = 2'd0;
    localparam logic [1:0] MODE_BLEND = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;
    localparam logic [1:0] MODE_LUMA  = 2'd3;

    localparam logic [7:0] FULL_SCALE   = 8'd255;
    localparam logic [7:0] FIXED_AMOUNT = 8'd185;

    // Brightness weights in thousandths, and the rounding scale 1000/4
    localparam int LUMA_W_RED   = 299;
    localparam int LUMA_W_GREEN = 587;
    localparam int LUMA_W_BLUE  = 114;
    localparam int LUMA_HALF    = 250;

    localparam int CH_W   = 8;
    localparam int PROD_W = 17;   // (c2 - c1) * w, signed
    localparam int SQR_W  = 16;   // channel squared
    localparam int SUM_W  = 26;   // weighted sum of squares

    // Pipeline layout: three color stages, then one root bit per stage
    localparam int SQRT_FIRST  = 3;
    localparam int SQRT_STAGES = CH_W;
    localparam int NUM_STAGES  = SQRT_FIRST + SQRT_STAGES;
    localparam int COLOR_DELAY = NUM_STAGES - SQRT_FIRST;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } color_t;

    // Per-stage load enables
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctl_t;

    // Signed product (b - a) * w
    function automatic logic signed [PROD_W-1:0] diff_mul(
        input logic [CH_W-1:0] a,
        input logic [CH_W-1:0] b,
        input logic [CH_W-1:0] w
    );
        logic signed [CH_W:0]     d;
        logic signed [2*CH_W+1:0] p;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, w});
        return p[PROD_W-1:0];
    endfunction

    // Signed divide by 255, truncating toward zero; |p| <= 255 * 255
    function automatic logic signed [CH_W:0] div255(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] t;
        logic [CH_W:0]     qm;
        mag = p[PROD_W-1] ? PROD_W'(-p) : p;
        t   = mag + (mag >> CH_W) + PROD_W'(1);
        qm  = {1'b0, t[2*CH_W-1:CH_W]};
        return p[PROD_W-1] ? -qm : qm;
    endfunction

    // Base channel plus signed step, modulo 256
    function automatic logic [CH_W-1:0] interp_add(
        input logic [CH_W-1:0]        c1,
        input logic signed [CH_W:0]   q
    );
        logic [CH_W:0] s;
        s = {1'b0, c1} + q;
        return s[CH_W-1:0];
    endfunction

endpackage

// ===== sv/rgbmix_ctrl.sv =====
`timescale 1ns / 1ps

module rgbmix_ctrl import rgbmix_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output pipe_ctl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] shifted;

    // Load a stage when it is empty or its successor moves on
    always_comb begin
        ctl.en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            ctl.en[i] = !valid_reg[i] || ctl.en[i+1];
        end
    end

    // Advance valid bits where enabled, hold elsewhere
    always_comb begin
        shifted    = {valid_reg[NUM_STAGES-2:0], s_valid};
        valid_next = (ctl.en & shifted) | (~ctl.en & valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = ctl.en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

endmodule

// ===== sv/rgbmix_color.sv =====
`timescale 1ns / 1ps

module rgbmix_color import rgbmix_pkg::*; (
    input  logic             aclk,
    input  pipe_ctl_t        ctl,
    input  logic [1:0]       mode,
    input  color_t           first,
    input  color_t           second,
    input  logic [CH_W-1:0]  weight,
    output logic [SUM_W-1:0] luma_sum,
    output color_t           result
);

    // Stage A: products and squares
    logic                     a_luma_reg, a_blend_reg;
    color_t                   a_c1_reg, a_c2_reg;
    logic [CH_W-1:0]          a_inv_a_reg, a_w_reg;
    logic signed [PROD_W-1:0] a_pa_reg, a_palpha_reg;
    logic [SQR_W-1:0]         a_rr_reg, a_gg_reg, a_bb_reg;
    logic [CH_W-1:0]          w_eff_next, inv_a_next;
    logic signed [PROD_W-1:0] pa_next, palpha_next;

    always_comb begin
        w_eff_next  = (mode == MODE_FIXED) ? FIXED_AMOUNT : weight;
        inv_a_next  = FULL_SCALE - first.alpha;
        pa_next     = diff_mul(inv_a_next, second.alpha, weight);
        palpha_next = diff_mul(first.alpha, second.alpha, w_eff_next);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            a_luma_reg   <= (mode == MODE_LUMA);
            a_blend_reg  <= (mode == MODE_BLEND);
            a_c1_reg     <= first;
            a_c2_reg     <= second;
            a_inv_a_reg  <= inv_a_next;
            a_w_reg      <= w_eff_next;
            a_pa_reg     <= pa_next;
            a_palpha_reg <= palpha_next;
            a_rr_reg     <= {8'd0, first.red} * {8'd0, first.red};
            a_gg_reg     <= {8'd0, first.green} * {8'd0, first.green};
            a_bb_reg     <= {8'd0, first.blue} * {8'd0, first.blue};
        end
    end

    // Stage B: blend weight, alpha result, weighted squares
    logic                 b_luma_reg;
    color_t               b_c1_reg, b_c2_reg;
    logic [CH_W-1:0]      b_m_reg;
    logic [SUM_W-1:0]     b_wr_reg, b_wg_reg, b_wb_reg;
    logic [CH_W-1:0]      m_next, alpha_next;

    always_comb begin
        m_next     = a_blend_reg ? interp_add(a_inv_a_reg, div255(a_pa_reg)) : a_w_reg;
        alpha_next = interp_add(a_c1_reg.alpha, div255(a_palpha_reg));
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[1]) begin
            b_luma_reg     <= a_luma_reg;
            b_c1_reg       <= '{red: a_c1_reg.red, green: a_c1_reg.green,
                                blue: a_c1_reg.blue, alpha: alpha_next};
            b_c2_reg       <= a_c2_reg;
            b_m_reg        <= m_next;
            b_wr_reg       <= SUM_W'(LUMA_W_RED) * SUM_W'(a_rr_reg);
            b_wg_reg       <= SUM_W'(LUMA_W_GREEN) * SUM_W'(a_gg_reg);
            b_wb_reg       <= SUM_W'(LUMA_W_BLUE) * SUM_W'(a_bb_reg);
        end
    end

    // Stage C: channel products, brightness sum (zero outside brightness mode)
    logic                     c_luma_reg;
    color_t                   c_c1_reg;
    logic signed [PROD_W-1:0] c_pr_reg, c_pg_reg, c_pb_reg;
    logic [SUM_W-1:0]         c_sum_reg;
    logic [SUM_W-1:0]         sum_next;

    always_comb begin
        sum_next = b_luma_reg ? (b_wr_reg + b_wg_reg + b_wb_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            c_luma_reg <= b_luma_reg;
            c_c1_reg   <= b_c1_reg;
            c_pr_reg   <= diff_mul(b_c1_reg.red, b_c2_reg.red, b_m_reg);
            c_pg_reg   <= diff_mul(b_c1_reg.green, b_c2_reg.green, b_m_reg);
            c_pb_reg   <= diff_mul(b_c1_reg.blue, b_c2_reg.blue, b_m_reg);
            c_sum_reg  <= sum_next;
        end
    end

    assign luma_sum = c_sum_reg;

    // Stage D: final color, then hold it alongside the root stages
    color_t res_next;
    color_t dly_reg [COLOR_DELAY];

    always_comb begin
        res_next.red   = interp_add(c_c1_reg.red, div255(c_pr_reg));
        res_next.green = interp_add(c_c1_reg.green, div255(c_pg_reg));
        res_next.blue  = interp_add(c_c1_reg.blue, div255(c_pb_reg));
        res_next.alpha = c_c1_reg.alpha;
        if (c_luma_reg) begin
            res_next = '0;
        end
    end

    for (genvar k = 0; k < COLOR_DELAY; k++) begin : g_dly
        if (k == 0) begin : g_head
            always_ff @(posedge aclk) begin
                if (ctl.en[SQRT_FIRST]) begin
                    dly_reg[0] <= res_next;
                end
            end
        end else begin : g_tail
            always_ff @(posedge aclk) begin
                if (ctl.en[SQRT_FIRST+k]) begin
                    dly_reg[k] <= dly_reg[k-1];
                end
            end
        end
    end

    assign result = dly_reg[COLOR_DELAY-1];

endmodule

// ===== sv/rgbmix_sqrt.sv =====
`timescale 1ns / 1ps

module rgbmix_sqrt import rgbmix_pkg::*; (
    input  logic             aclk,
    input  pipe_ctl_t        ctl,
    input  logic [SUM_W-1:0] luma_sum,
    output logic [CH_W-1:0]  luma
);

    // Largest n with 250 * (2n - 1)^2 <= S, resolved one bit per stage from the MSB
    logic [CH_W-1:0]  n_reg [SQRT_STAGES];
    logic [SUM_W-1:0] s_reg [SQRT_STAGES-1];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_bit
        localparam int BIT = SQRT_STAGES - 1 - g;

        logic [CH_W-1:0]   n_in;
        logic [SUM_W-1:0]  s_in;
        logic [CH_W-1:0]   cand;
        logic [CH_W:0]     odd;
        logic [2*CH_W+1:0] odd_sq;
        logic [SUM_W-1:0]  lhs;
        logic [CH_W-1:0]   n_next;

        if (g == 0) begin : g_src
            assign n_in = '0;
            assign s_in = luma_sum;
        end else begin : g_chain
            assign n_in = n_reg[g-1];
            assign s_in = s_reg[g-1];
        end

        // Try setting this bit; keep it if the rounded square still fits
        always_comb begin
            cand   = n_in | (CH_W'(1) << BIT);
            odd    = {cand, 1'b0} - (CH_W+1)'(1);
            odd_sq = {{(CH_W+1){1'b0}}, odd} * {{(CH_W+1){1'b0}}, odd};
            lhs    = SUM_W'(LUMA_HALF) * SUM_W'(odd_sq);
            n_next = (lhs <= s_in) ? cand : n_in;
        end

        always_ff @(posedge aclk) begin
            if (ctl.en[SQRT_FIRST+g]) begin
                n_reg[g] <= n_next;
            end
        end

        if (g < SQRT_STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (ctl.en[SQRT_FIRST+g]) begin
                    s_reg[g] <= s_in;
                end
            end
        end
    end

    assign luma = n_reg[SQRT_STAGES-1];

endmodule

// ===== sv/rgba_color_mix_blend_brightness_top.sv =====
`timescale 1ns / 1ps
// One item per cycle is accepted while the output is not stalled; three color
// stages feed eight root stages, each of which resolves one bit of the brightness.
// Stages load independently, so bubbles close up while the output is stalled.
// Reset (aresetn low, synchronous) empties the pipeline; data registers keep junk.

module rgba_color_mix_blend_brightness_top import rgbmix_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    input  logic [CH_W-1:0]  s_first_red,
    input  logic [CH_W-1:0]  s_first_green,
    input  logic [CH_W-1:0]  s_first_blue,
    input  logic [CH_W-1:0]  s_first_alpha,
    input  logic [CH_W-1:0]  s_second_red,
    input  logic [CH_W-1:0]  s_second_green,
    input  logic [CH_W-1:0]  s_second_blue,
    input  logic [CH_W-1:0]  s_second_alpha,
    input  logic [CH_W-1:0]  s_weight,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CH_W-1:0]  m_out_red,
    output logic [CH_W-1:0]  m_out_green,
    output logic [CH_W-1:0]  m_out_blue,
    output logic [CH_W-1:0]  m_out_alpha,
    output logic [CH_W-1:0]  m_luma
);

    pipe_ctl_t        ctl;
    color_t           first, second, result;
    logic [SUM_W-1:0] luma_sum;

    // Pack the colors
    assign first  = '{red: s_first_red, green: s_first_green,
                      blue: s_first_blue, alpha: s_first_alpha};
    assign second = '{red: s_second_red, green: s_second_green,
                      blue: s_second_blue, alpha: s_second_alpha};

    rgbmix_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    rgbmix_color u_color (
        .aclk     (aclk),
        .ctl      (ctl),
        .mode     (s_mode),
        .first    (first),
        .second   (second),
        .weight   (s_weight),
        .luma_sum (luma_sum),
        .result   (result)
    );

    rgbmix_sqrt u_sqrt (
        .aclk     (aclk),
        .ctl      (ctl),
        .luma_sum (luma_sum),
        .luma     (m_luma)
    );

    assign m_out_red   = result.red;
    assign m_out_green = result.green;
    assign m_out_blue  = result.blue;
    assign m_out_alpha = result.alpha;

endmodule
